[src/sce_pkg.sv]
package sce_pkg;

  localparam logic [7:0] CH_ETX      = 8'h03;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_LF       = 8'h0a;
  localparam logic [7:0] CH_CR       = 8'h0d;
  localparam logic [7:0] CH_SP       = 8'h20;
  localparam logic [7:0] CH_DEL      = 8'h7f;
  localparam logic [7:0] CH_PRINT_LO = 8'd32;
  localparam logic [7:0] CH_PRINT_HI = 8'd126;

  localparam logic [1:0] BEAT_FIRST  = 2'd0;
  localparam logic [1:0] BEAT_SECOND = 2'd1;
  localparam logic [1:0] BEAT_THIRD  = 2'd2;

  typedef enum logic [2:0] {
    K_EMPTY,
    K_ECHO,
    K_ERASE,
    K_NEWLINE,
    K_BREAK,
    K_READ
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] len;
    logic       hit;
  } item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       line_ready;
    logic [7:0] line_length;
    logic       break_event;
    logic [7:0] read_char;
    logic       last;
  } res_t;

endpackage

[src/sce_if.sv]
interface sce_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] rx_byte;
  logic [7:0] read_index;

  modport source (output valid, output op, output rx_byte, output read_index, input ready);
  modport sink (input valid, input op, input rx_byte, input read_index, output ready);
endinterface

interface sce_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       line_ready;
  logic [7:0] line_length;
  logic       break_event;
  logic [7:0] read_char;
  logic       last;

  modport source (
    output valid, output tx_valid, output tx_byte, output line_ready,
    output line_length, output break_event, output read_char, output last,
    input ready
  );
  modport sink (
    input valid, input tx_valid, input tx_byte, input line_ready,
    input line_length, input break_event, input read_char, input last,
    output ready
  );
endinterface

[src/sce_line_mem.sv]
module sce_line_mem #(
  parameter int Depth = 255,
  parameter int AddrW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/sce_decode.sv]
module sce_decode #(
  parameter int Capacity = 255,
  parameter int CntW     = 8,
  parameter int AddrW    = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic                 op_i,
  input  logic [7:0]           rx_byte_i,
  input  logic [7:0]           read_index_i,
  output sce_pkg::item_t       item_o,
  output logic                 we_o,
  output logic [AddrW-1:0]     waddr_o,
  output logic                 re_o,
  output logic [AddrW-1:0]     raddr_o
);
  import sce_pkg::*;

  localparam int CmpW = (CntW > 8) ? CntW : 8;

  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] compl_q, compl_d;
  logic [CmpW-1:0] idx_ext, compl_ext, fill_ext;
  logic            hit, room;

  assign idx_ext   = CmpW'(read_index_i);
  assign compl_ext = CmpW'(compl_q);
  assign fill_ext  = CmpW'(fill_q);
  assign hit       = (idx_ext < compl_ext) && (idx_ext < CmpW'(Capacity));
  assign room      = fill_q < CntW'(Capacity);
  assign waddr_o   = fill_q[AddrW-1:0];
  assign raddr_o   = idx_ext[AddrW-1:0];

  always_comb begin
    item_o.kind = K_EMPTY;
    item_o.data = rx_byte_i;
    item_o.len  = fill_ext[7:0];
    item_o.hit  = hit;
    fill_d      = fill_q;
    compl_d     = compl_q;
    we_o        = 1'b0;
    re_o        = 1'b0;
    if (op_i) begin
      item_o.kind = K_READ;
      re_o        = accept_i && hit;
    end else begin
      case (rx_byte_i)
        CH_CR: begin
          item_o.kind = K_NEWLINE;
          compl_d     = fill_q;
          fill_d      = '0;
        end
        CH_BS, CH_DEL: begin
          if (fill_q != '0) begin
            item_o.kind = K_ERASE;
            fill_d      = fill_q - CntW'(1);
          end
        end
        CH_ETX: begin
          item_o.kind = K_BREAK;
          fill_d      = '0;
        end
        default: begin
          if ((rx_byte_i inside {[CH_PRINT_LO:CH_PRINT_HI]}) && room) begin
            item_o.kind = K_ECHO;
            we_o        = accept_i;
            fill_d      = fill_q + CntW'(1);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      compl_q <= '0;
    end else if (accept_i) begin
      fill_q  <= fill_d;
      compl_q <= compl_d;
    end
  end

endmodule

[src/sce_seq.sv]
module sce_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  sce_pkg::item_t item_i,
  input  logic [7:0]     rdata_i,
  output logic           in_ready_o,
  sce_out_if.source      out_o
);
  import sce_pkg::*;

  logic       s1_valid_q;
  item_t      item_q;
  logic [1:0] beat_q;
  logic       out_valid_q;
  res_t       out_q;
  res_t       res;
  logic       out_free, s1_adv, s1_done;

  always_comb begin
    res = '0;
    case (item_q.kind)
      K_ECHO: begin
        res.tx_valid = 1'b1;
        res.tx_byte  = item_q.data;
        res.last     = 1'b1;
      end
      K_ERASE: begin
        res.tx_valid = 1'b1;
        res.tx_byte  = (beat_q == BEAT_SECOND) ? CH_SP : CH_BS;
        res.last     = (beat_q == BEAT_THIRD);
      end
      K_NEWLINE: begin
        res.tx_valid = 1'b1;
        if (beat_q == BEAT_FIRST) begin
          res.tx_byte = CH_CR;
        end else begin
          res.tx_byte     = CH_LF;
          res.line_ready  = 1'b1;
          res.line_length = item_q.len;
          res.last        = 1'b1;
        end
      end
      K_BREAK: begin
        res.tx_valid = 1'b1;
        if (beat_q == BEAT_FIRST) begin
          res.tx_byte = CH_CR;
        end else begin
          res.tx_byte     = CH_LF;
          res.break_event = 1'b1;
          res.last        = 1'b1;
        end
      end
      K_READ: begin
        res.read_char = item_q.hit ? rdata_i : 8'd0;
        res.last      = 1'b1;
      end
      default: begin
        res.last = 1'b1;
      end
    endcase
  end

  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_adv     = s1_valid_q && out_free;
  assign s1_done    = s1_adv && res.last;
  assign in_ready_o = !s1_valid_q || s1_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      beat_q     <= BEAT_FIRST;
    end else if (accept_i) begin
      s1_valid_q <= 1'b1;
      beat_q     <= BEAT_FIRST;
    end else if (s1_done) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      beat_q <= beat_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= item_i;
    end
    if (s1_adv) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.tx_valid    = out_q.tx_valid;
  assign out_o.tx_byte     = out_q.tx_byte;
  assign out_o.line_ready  = out_q.line_ready;
  assign out_o.line_length = out_q.line_length;
  assign out_o.break_event = out_q.break_event;
  assign out_o.read_char   = out_q.read_char;
  assign out_o.last        = out_q.last;

endmodule

[src/serial_console_line_editor.sv]
// An input transfer loads the sequencer stage, and each result is then registered in the
// output register before it is offered.
// Each input gives one result, but carriage return and Ctrl-C give two (CR, LF) and an erase
// three (BS, SP, BS); the sequencer emits one result per cycle unless the output stalls.
// Character reads use the line memory's registered read port, loaded on the input transfer.
// Reset clears the fill count, completed length and all valid flags; the line memory
// is not cleared and holds unknown data until written.
module serial_console_line_editor #(
  parameter int LINE_CAPACITY = 255
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sce_in_if.sink     in_i,
  sce_out_if.source  out_o
);
  import sce_pkg::*;

  localparam int CntW  = $clog2(LINE_CAPACITY + 1);
  localparam int AddrW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;

  logic             accept;
  logic             in_ready;
  item_t            item;
  logic             mem_we, mem_re;
  logic [AddrW-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_rdata;

  assign in_i.ready = in_ready;
  assign accept     = in_i.valid && in_ready;

  sce_decode #(
    .Capacity (LINE_CAPACITY),
    .CntW     (CntW),
    .AddrW    (AddrW)
  ) u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .op_i         (in_i.op),
    .rx_byte_i    (in_i.rx_byte),
    .read_index_i (in_i.read_index),
    .item_o       (item),
    .we_o         (mem_we),
    .waddr_o      (mem_waddr),
    .re_o         (mem_re),
    .raddr_o      (mem_raddr)
  );

  sce_line_mem #(
    .Depth (LINE_CAPACITY),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_i.rx_byte),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sce_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (item),
    .rdata_i    (mem_rdata),
    .in_ready_o (in_ready),
    .out_o      (out_o)
  );

  a_write_on_transfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (accept && item.kind == K_ECHO))
    else $error("line memory written without an echoed transfer");

  a_read_on_read_op : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> (accept && item.kind == K_READ && item.hit))
    else $error("line memory read outside a read transfer");

  a_ready_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.line_ready) |-> (out_o.last && out_o.tx_byte == CH_LF))
    else $error("line ready not on the final line feed");

  a_result_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> (out_o.valid && $stable(out_o.tx_byte)))
    else $error("stalled result changed");

endmodule
